// ===== design/wft_pkg.sv =====
package wft_pkg;

    localparam int CAPACITY_DEF    = 16;
    localparam int MAX_LETTERS_DEF = 8;
    localparam int COUNT_WIDTH_DEF = 16;

    localparam int WORD_W     = 64;
    localparam int WORD_BYTES = 8;
    localparam int LEN_W      = 4;
    localparam int SLOT_W     = 4;
    localparam int FREQ_W     = 16;
    localparam int DIST_W     = 5;

    localparam logic MODE_ADD    = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    typedef logic [1:0] step_op_t;

    localparam step_op_t OP_HOLD = 2'd0;
    localparam step_op_t OP_INC  = 2'd1;
    localparam step_op_t OP_DEC  = 2'd2;

    typedef struct packed {
        logic eq;
        logic at_max;
        logic above_one;
    } unit_flags_t;

endpackage

// ===== design/wft_ram.sv =====
module wft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== design/wft_unit.sv =====
module wft_unit #(
    parameter int COUNT_WIDTH = wft_pkg::COUNT_WIDTH_DEF
) (
    input  logic [wft_pkg::WORD_W-1:0] entry_word,
    input  logic [wft_pkg::LEN_W-1:0]  entry_len,
    input  logic [wft_pkg::WORD_W-1:0] key_word,
    input  logic [wft_pkg::LEN_W-1:0]  key_len,
    input  wft_pkg::step_op_t          op,
    input  logic [COUNT_WIDTH-1:0]     value,
    output logic [COUNT_WIDTH-1:0]     result,
    output wft_pkg::unit_flags_t       flags
);

    always_comb
    begin
        flags.eq        = (entry_word == key_word) && (entry_len == key_len);
        flags.at_max    = &value;
        flags.above_one = value > COUNT_WIDTH'(1);
    end

    // saturating step in both directions
    always_comb
    begin
        case (op)
            wft_pkg::OP_INC: result = flags.at_max ? value : value + COUNT_WIDTH'(1);
            wft_pkg::OP_DEC: result = (value == '0) ? value : value - COUNT_WIDTH'(1);
            default:         result = value;
        endcase
    end

endmodule

// ===== design/word_frequency_table.sv =====
// Word frequency table: up to CAPACITY distinct words with saturating counts,
// plus a distinct-word tally and a summed count for each word length.
// Input channel (in_valid/in_ready) carries one request: mode (0 add, 1 remove),
// word (letters packed from the low byte) and word_length. Bytes at and above
// word_length are treated as zero. Output channel (out_valid/out_ready) returns
// exactly one result per request.
// The search reads one entry per cycle from the single-port-read entry memory
// through one shared comparator, until a match or the end of the stored words;
// a freed slot costs one extra read and write to move the last entry. A request
// of invalid length skips the search and goes straight to the tally step.
// The block takes one request at a time; in_ready is high only while idle.
// A finished result sits in the output register; the next request can be taken
// while it waits, but that request does not complete until out_ready takes the
// earlier result.
// Reset (rst_n low, asynchronous) empties the table and clears all tallies
// at once; the entry memory needs no clearing.
module word_frequency_table #(
    parameter int CAPACITY    = wft_pkg::CAPACITY_DEF,
    parameter int MAX_LETTERS = wft_pkg::MAX_LETTERS_DEF,
    parameter int COUNT_WIDTH = wft_pkg::COUNT_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        mode,
    input  logic [wft_pkg::WORD_W-1:0]  word,
    input  logic [wft_pkg::LEN_W-1:0]   word_length,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        was_present,
    output logic [wft_pkg::SLOT_W-1:0]  slot,
    output logic [wft_pkg::FREQ_W-1:0]  new_freq,
    output logic                        table_full_error,
    output logic [wft_pkg::DIST_W-1:0]  distinct_words,
    output logic [wft_pkg::DIST_W-1:0]  distinct_of_length,
    output logic [wft_pkg::FREQ_W-1:0]  freq_sum_of_length
);

    localparam int IDX_W   = $clog2(CAPACITY);
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int LI_W    = (MAX_LETTERS > 1) ? $clog2(MAX_LETTERS) : 1;
    localparam int ENTRY_W = wft_pkg::WORD_W + wft_pkg::LEN_W + COUNT_WIDTH;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_UPD   = 3'd2;
    localparam logic [2:0] S_MVRD  = 3'd3;
    localparam logic [2:0] S_MVWR  = 3'd4;
    localparam logic [2:0] S_TALLY = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    function automatic logic [wft_pkg::WORD_W-1:0] mask_word(
        input logic [wft_pkg::WORD_W-1:0] w,
        input logic [wft_pkg::LEN_W-1:0]  len
    );
        logic [wft_pkg::WORD_W-1:0] m;
        for (int i = 0; i < wft_pkg::WORD_BYTES; i++)
        begin
            m[8*i +: 8] = (wft_pkg::LEN_W'(i) < len) ? w[8*i +: 8] : 8'h00;
        end
        return m;
    endfunction

    // control state
    logic [2:0]             state_reg, state_next;
    logic [CNT_W-1:0]       scan_reg, scan_next;
    logic                   pend_reg, pend_next;
    logic [CNT_W-1:0]       used_reg, used_next;
    logic [CNT_W-1:0]       wpl_reg [MAX_LETTERS];
    logic [CNT_W-1:0]       wpl_next;
    logic [COUNT_WIDTH-1:0] sum_reg [MAX_LETTERS];
    logic                   out_valid_reg;

    // request payload and working values
    logic                       mode_reg, mode_next;
    logic [wft_pkg::WORD_W-1:0] key_reg, key_next;
    logic [wft_pkg::LEN_W-1:0]  len_reg, len_next;
    logic                       lv_reg, lv_next;
    logic [LI_W-1:0]            li_reg, li_next;
    logic [IDX_W-1:0]           cmp_reg, cmp_next;
    logic [IDX_W-1:0]           pos_reg, pos_next;
    logic [COUNT_WIDTH-1:0]     cnt_reg, cnt_next;
    logic [COUNT_WIDTH-1:0]     freq_reg, freq_next;
    logic                       found_reg, found_next;
    logic                       err_reg, err_next;
    wft_pkg::step_op_t          sum_op_reg, sum_op_next;
    wft_pkg::step_op_t          wpl_op_reg, wpl_op_next;
    wft_pkg::step_op_t          used_op_reg, used_op_next;

    // result register
    logic                        present_reg;
    logic [wft_pkg::SLOT_W-1:0]  slot_reg;
    logic [wft_pkg::FREQ_W-1:0]  new_freq_reg;
    logic                        error_reg;
    logic [wft_pkg::DIST_W-1:0]  distinct_reg;
    logic [wft_pkg::DIST_W-1:0]  dist_len_reg;
    logic [wft_pkg::FREQ_W-1:0]  sum_len_reg;

    // memory and shared unit
    logic                       wr_en;
    logic [IDX_W-1:0]           wr_addr;
    logic [ENTRY_W-1:0]         wr_data;
    logic [IDX_W-1:0]           rd_addr;
    logic [ENTRY_W-1:0]         rd_data;
    logic [wft_pkg::WORD_W-1:0] rd_word;
    logic [wft_pkg::LEN_W-1:0]  rd_len;
    logic [COUNT_WIDTH-1:0]     rd_cnt;

    wft_pkg::step_op_t      unit_op;
    logic [COUNT_WIDTH-1:0] unit_val;
    logic [COUNT_WIDTH-1:0] unit_res;
    wft_pkg::unit_flags_t   flags;

    logic                   in_len_ok;
    logic [CNT_W-1:0]       last_pos;
    logic                   out_load;
    logic [31:0]            pos_ext, freq_ext, used_ext, wpl_ext, sum_ext;

    assign rd_word = rd_data[wft_pkg::WORD_W-1:0];
    assign rd_len  = rd_data[wft_pkg::WORD_W +: wft_pkg::LEN_W];
    assign rd_cnt  = rd_data[ENTRY_W-1 -: COUNT_WIDTH];

    assign in_len_ok = (word_length != '0) &&
                       (word_length <= wft_pkg::LEN_W'(MAX_LETTERS));
    assign last_pos  = used_reg - CNT_W'(1);
    assign in_ready  = (state_reg == S_IDLE);
    assign out_load  = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    wft_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_entries (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    wft_unit #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_unit (
        .entry_word (rd_word),
        .entry_len  (rd_len),
        .key_word   (key_reg),
        .key_len    (len_reg),
        .op         (unit_op),
        .value      (unit_val),
        .result     (unit_res),
        .flags      (flags)
    );

    always_comb
    begin
        state_next   = state_reg;
        scan_next    = scan_reg;
        pend_next    = pend_reg;
        mode_next    = mode_reg;
        key_next     = key_reg;
        len_next     = len_reg;
        lv_next      = lv_reg;
        li_next      = li_reg;
        cmp_next     = cmp_reg;
        pos_next     = pos_reg;
        cnt_next     = cnt_reg;
        freq_next    = freq_reg;
        found_next   = found_reg;
        err_next     = err_reg;
        sum_op_next  = sum_op_reg;
        wpl_op_next  = wpl_op_reg;
        used_op_next = used_op_reg;
        unit_op      = wft_pkg::OP_HOLD;
        unit_val     = cnt_reg;
        wr_en        = 1'b0;
        wr_addr      = pos_reg;
        wr_data      = {unit_res, len_reg, key_reg};
        rd_addr      = scan_reg[IDX_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    mode_next    = mode;
                    key_next     = mask_word(word, word_length);
                    len_next     = word_length;
                    lv_next      = in_len_ok;
                    li_next      = in_len_ok ? LI_W'(word_length - wft_pkg::LEN_W'(1)) : '0;
                    scan_next    = '0;
                    pend_next    = 1'b0;
                    found_next   = 1'b0;
                    err_next     = 1'b0;
                    pos_next     = '0;
                    freq_next    = '0;
                    sum_op_next  = wft_pkg::OP_HOLD;
                    wpl_op_next  = wft_pkg::OP_HOLD;
                    used_op_next = wft_pkg::OP_HOLD;
                    state_next   = in_len_ok ? S_SCAN : S_TALLY;
                end
            end

            // issue one read per cycle, compare the entry read the cycle before
            S_SCAN:
            begin
                if (pend_reg && flags.eq)
                begin
                    found_next = 1'b1;
                    pos_next   = cmp_reg;
                    cnt_next   = rd_cnt;
                    state_next = S_UPD;
                end
                else if (scan_reg >= used_reg)
                begin
                    if (mode_reg == wft_pkg::MODE_ADD)
                    begin
                        if (used_reg >= CNT_W'(CAPACITY))
                        begin
                            err_next = 1'b1;
                        end
                        else
                        begin
                            // append at the end of the table
                            wr_en        = 1'b1;
                            wr_addr      = used_reg[IDX_W-1:0];
                            wr_data      = {COUNT_WIDTH'(1), len_reg, key_reg};
                            pos_next     = used_reg[IDX_W-1:0];
                            freq_next    = COUNT_WIDTH'(1);
                            sum_op_next  = wft_pkg::OP_INC;
                            wpl_op_next  = wft_pkg::OP_INC;
                            used_op_next = wft_pkg::OP_INC;
                        end
                    end
                    state_next = S_TALLY;
                end
                else
                begin
                    pend_next = 1'b1;
                    cmp_next  = scan_reg[IDX_W-1:0];
                    scan_next = scan_reg + CNT_W'(1);
                end
            end

            S_UPD:
            begin
                unit_val = cnt_reg;
                if (mode_reg == wft_pkg::MODE_ADD)
                begin
                    unit_op     = wft_pkg::OP_INC;
                    wr_en       = 1'b1;
                    freq_next   = unit_res;
                    sum_op_next = flags.at_max ? wft_pkg::OP_HOLD : wft_pkg::OP_INC;
                    state_next  = S_TALLY;
                end
                else
                begin
                    sum_op_next = wft_pkg::OP_DEC;
                    if (flags.above_one)
                    begin
                        unit_op    = wft_pkg::OP_DEC;
                        wr_en      = 1'b1;
                        freq_next  = unit_res;
                        state_next = S_TALLY;
                    end
                    else
                    begin
                        // free the slot: move the last entry into it
                        freq_next    = '0;
                        wpl_op_next  = wft_pkg::OP_DEC;
                        used_op_next = wft_pkg::OP_DEC;
                        state_next   = S_MVRD;
                    end
                end
            end

            S_MVRD:
            begin
                rd_addr    = last_pos[IDX_W-1:0];
                state_next = S_MVWR;
            end

            S_MVWR:
            begin
                wr_en      = 1'b1;
                wr_addr    = pos_reg;
                wr_data    = rd_data;
                state_next = S_TALLY;
            end

            S_TALLY:
            begin
                unit_val   = sum_reg[li_reg];
                unit_op    = sum_op_reg;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        case (wpl_op_reg)
            wft_pkg::OP_INC: wpl_next = wpl_reg[li_reg] + CNT_W'(1);
            wft_pkg::OP_DEC: wpl_next = (wpl_reg[li_reg] == '0) ? wpl_reg[li_reg]
                                                              : wpl_reg[li_reg] - CNT_W'(1);
            default:         wpl_next = wpl_reg[li_reg];
        endcase
        case (used_op_reg)
            wft_pkg::OP_INC: used_next = used_reg + CNT_W'(1);
            wft_pkg::OP_DEC: used_next = last_pos;
            default:         used_next = used_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            scan_reg      <= '0;
            pend_reg      <= 1'b0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_LETTERS; i++)
            begin
                wpl_reg[i] <= '0;
                sum_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            scan_reg  <= scan_next;
            pend_reg  <= pend_next;
            if (state_reg == S_TALLY)
            begin
                used_reg        <= used_next;
                wpl_reg[li_reg] <= wpl_next;
                sum_reg[li_reg] <= unit_res;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign pos_ext  = 32'(pos_reg);
    assign freq_ext = 32'(freq_reg);
    assign used_ext = 32'(used_reg);
    assign wpl_ext  = 32'(wpl_reg[li_reg]);
    assign sum_ext  = 32'(sum_reg[li_reg]);

    always_ff @(posedge clk)
    begin
        mode_reg    <= mode_next;
        key_reg     <= key_next;
        len_reg     <= len_next;
        lv_reg      <= lv_next;
        li_reg      <= li_next;
        cmp_reg     <= cmp_next;
        pos_reg     <= pos_next;
        cnt_reg     <= cnt_next;
        freq_reg    <= freq_next;
        found_reg   <= found_next;
        err_reg     <= err_next;
        sum_op_reg  <= sum_op_next;
        wpl_op_reg  <= wpl_op_next;
        used_op_reg <= used_op_next;
        if (out_load)
        begin
            present_reg  <= found_reg;
            slot_reg     <= pos_ext[wft_pkg::SLOT_W-1:0];
            new_freq_reg <= freq_ext[wft_pkg::FREQ_W-1:0];
            error_reg    <= err_reg;
            distinct_reg <= used_ext[wft_pkg::DIST_W-1:0];
            dist_len_reg <= lv_reg ? wpl_ext[wft_pkg::DIST_W-1:0] : '0;
            sum_len_reg  <= lv_reg ? sum_ext[wft_pkg::FREQ_W-1:0] : '0;
        end
    end

    assign out_valid          = out_valid_reg;
    assign was_present        = present_reg;
    assign slot               = slot_reg;
    assign new_freq           = new_freq_reg;
    assign table_full_error   = error_reg;
    assign distinct_words     = distinct_reg;
    assign distinct_of_length = dist_len_reg;
    assign freq_sum_of_length = sum_len_reg;

`ifndef NO_ASSERTIONS
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CNT_W'(CAPACITY))
        else $error("stored word count exceeds capacity");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while another is in progress");

    a_write_window: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == S_SCAN || state_reg == S_UPD || state_reg == S_MVWR))
        else $error("entry memory written outside an update step");

    a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && table_full_error |-> !was_present && new_freq == '0)
        else $error("table full result reports a stored word");
`endif

endmodule

// ===== sim/testbench.sv =====
module testbench;

    localparam int          WORD_W        = wft_pkg::WORD_W;
    localparam int          WORD_BYTES    = wft_pkg::WORD_BYTES;
    localparam int          LEN_W         = wft_pkg::LEN_W;
    localparam int          SLOT_W        = wft_pkg::SLOT_W;
    localparam int          FREQ_W        = wft_pkg::FREQ_W;
    localparam int          DIST_W        = wft_pkg::DIST_W;
    localparam logic        MODE_ADD      = wft_pkg::MODE_ADD;
    localparam logic        MODE_REMOVE   = wft_pkg::MODE_REMOVE;
    localparam int          TABLE_SLOTS   = wft_pkg::CAPACITY_DEF;
    localparam int          LETTERS_MAX   = wft_pkg::MAX_LETTERS_DEF;
    localparam int unsigned COUNT_TOP     = (1 << wft_pkg::COUNT_WIDTH_DEF) - 1;
    localparam int          VOCAB_SIZE    = 24;
    localparam int          SEGMENTS      = 14;
    localparam int          SEGMENT_ITEMS = 65;
    localparam int          TAIL_ITEMS    = 60;
    localparam int          LONG_HOLD     = 400;
    localparam int          SETTLE_CYCLES = 40;
    localparam int          CYCLE_LIMIT   = 3_000_000;

    typedef struct {
        logic              present;
        logic [SLOT_W-1:0] slot;
        logic [FREQ_W-1:0] freq;
        logic              full_err;
        logic [DIST_W-1:0] total;
        logic [DIST_W-1:0] of_len;
        logic [FREQ_W-1:0] len_sum;
    } lookup_result_t;

    class word_table_model;
        logic [WORD_W-1:0] letters [TABLE_SLOTS];
        logic [LEN_W-1:0]  lens [TABLE_SLOTS];
        int unsigned       counts [TABLE_SLOTS];
        int unsigned       used;
        int unsigned       words_of_len [LETTERS_MAX];
        int unsigned       sum_of_len [LETTERS_MAX];
        lookup_result_t    pending_lookups [$];
        int                mismatches;

        function lookup_result_t apply_request(logic op, logic [WORD_W-1:0] raw,
                                               logic [LEN_W-1:0] len);
            lookup_result_t r;
            logic [WORD_W-1:0] w;
            int li;
            int pos;
            int last;
            bit found;
            r = '{default: '0};
            if (len == 0 || len > LETTERS_MAX)
            begin
                r.total = DIST_W'(used);
                return r;
            end
            li = len - 1;
            w = (len >= WORD_BYTES) ? raw : raw & ((64'd1 << (8 * len)) - 64'd1);
            found = 0;
            pos = 0;
            for (int i = 0; i < used; i++)
            begin
                if (!found && letters[i] == w && lens[i] == len)
                begin
                    found = 1;
                    pos = i;
                end
            end
            if (op == MODE_ADD)
            begin
                if (found)
                begin
                    if (counts[pos] < COUNT_TOP)
                    begin
                        counts[pos]++;
                        if (sum_of_len[li] < COUNT_TOP)
                            sum_of_len[li]++;
                    end
                    r.present = 1'b1;
                    r.slot = SLOT_W'(pos);
                    r.freq = FREQ_W'(counts[pos]);
                end
                else if (used >= TABLE_SLOTS)
                begin
                    r.full_err = 1'b1;
                end
                else
                begin
                    pos = used;
                    letters[pos] = w;
                    lens[pos] = len;
                    counts[pos] = 1;
                    used++;
                    words_of_len[li]++;
                    if (sum_of_len[li] < COUNT_TOP)
                        sum_of_len[li]++;
                    r.slot = SLOT_W'(pos);
                    r.freq = FREQ_W'(1);
                end
            end
            else if (found)
            begin
                if (sum_of_len[li] > 0)
                    sum_of_len[li]--;
                r.present = 1'b1;
                r.slot = SLOT_W'(pos);
                if (counts[pos] > 1)
                begin
                    counts[pos]--;
                    r.freq = FREQ_W'(counts[pos]);
                end
                else
                begin
                    // fill the freed slot from the last entry
                    last = used - 1;
                    letters[pos] = letters[last];
                    lens[pos] = lens[last];
                    counts[pos] = counts[last];
                    used = last;
                    if (words_of_len[li] > 0)
                        words_of_len[li]--;
                end
            end
            r.total = DIST_W'(used);
            r.of_len = DIST_W'(words_of_len[li]);
            r.len_sum = FREQ_W'(sum_of_len[li]);
            return r;
        endfunction

        function void note_request(logic op, logic [WORD_W-1:0] raw, logic [LEN_W-1:0] len);
            pending_lookups.push_back(apply_request(op, raw, len));
        endfunction

        task report_mismatch(string what);
            mismatches++;
            $display("mismatch: %s", what);
        endtask

        task compare_field(string name, logic [63:0] got, logic [63:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
        endtask

        task check_result(lookup_result_t got);
            lookup_result_t want;
            if (pending_lookups.size() == 0)
            begin
                report_mismatch("result with no request pending");
                return;
            end
            want = pending_lookups.pop_front();
            compare_field("was_present", 64'(got.present), 64'(want.present));
            compare_field("slot", 64'(got.slot), 64'(want.slot));
            compare_field("new_freq", 64'(got.freq), 64'(want.freq));
            compare_field("table_full_error", 64'(got.full_err), 64'(want.full_err));
            compare_field("distinct_words", 64'(got.total), 64'(want.total));
            compare_field("distinct_of_length", 64'(got.of_len), 64'(want.of_len));
            compare_field("freq_sum_of_length", 64'(got.len_sum), 64'(want.len_sum));
        endtask
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic              mode = MODE_ADD;
    logic [WORD_W-1:0] word = '0;
    logic [LEN_W-1:0]  word_length = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic              was_present;
    logic [SLOT_W-1:0] slot;
    logic [FREQ_W-1:0] new_freq;
    logic              table_full_error;
    logic [DIST_W-1:0] distinct_words;
    logic [DIST_W-1:0] distinct_of_length;
    logic [FREQ_W-1:0] freq_sum_of_length;

    word_table_model   word_table = new();
    logic [WORD_W-1:0] vocab_letters [VOCAB_SIZE];
    logic [LEN_W-1:0]  vocab_len [VOCAB_SIZE];
    int                stall_pct = 0;
    bit                hold_off_request = 1'b0;
    int unsigned       cycle_count = 0;

    word_frequency_table i_dut (.*);

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            word_table.check_result('{was_present, slot, new_freq, table_full_error,
                                      distinct_words, distinct_of_length,
                                      freq_sum_of_length});
    end

    // result side: random stall bursts, plus one long hold-off on request
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off_request)
            begin
                hold_off_request = 1'b0;
                out_ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(posedge clk);
            end
            else if (stall_pct != 0 && $urandom_range(99) < stall_pct)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(0, 9)) @(posedge clk);
            end
            else
                out_ready <= 1'b1;
        end
    end

    function automatic logic [WORD_W-1:0] letter_mask(logic [LEN_W-1:0] len);
        if (len >= WORD_BYTES)
            return '1;
        return (64'd1 << (8 * len)) - 64'd1;
    endfunction

    task automatic send_request(logic op, logic [WORD_W-1:0] raw, logic [LEN_W-1:0] len);
        in_valid <= 1'b1;
        mode <= op;
        word <= raw;
        word_length <= len;
        do
            @(posedge clk);
        while (!in_ready);
        word_table.note_request(op, raw, len);
    endtask

    task automatic pause_sender(int cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // mostly vocabulary words, half with junk above the length, some random words,
    // a few bad lengths
    task automatic send_random_item(int add_pct, output bit counted);
        logic [WORD_W-1:0] raw;
        logic [LEN_W-1:0]  len;
        logic              op;
        int                pick;
        int                roll;
        roll = $urandom_range(99);
        op = ($urandom_range(99) < add_pct) ? MODE_ADD : MODE_REMOVE;
        raw = {$urandom, $urandom};
        if (roll < 5)
        begin
            if ($urandom_range(3) == 0)
                len = '0;
            else
                len = LEN_W'($urandom_range(9, 15));
        end
        else if (roll < 15)
            len = LEN_W'($urandom_range(1, LETTERS_MAX));
        else
        begin
            pick = $urandom_range(VOCAB_SIZE - 1);
            len = vocab_len[pick];
            if ($urandom_range(1) == 0)
                raw = vocab_letters[pick];
            else
                raw = vocab_letters[pick] | (raw & ~letter_mask(len));
        end
        counted = (len != 0 && len <= LETTERS_MAX);
        send_request(op, raw, len);
    endtask

    initial
    begin
        int                in_segment;
        int                add_pct;
        int                gap_pct;
        bit                took;
        logic [WORD_W-1:0] top_letters;
        logic [LEN_W-1:0]  top_len;

        // odd entries reuse the previous letters under another length
        for (int i = 0; i < VOCAB_SIZE; i++)
        begin
            if (i % 2 == 1)
            begin
                vocab_len[i] = LEN_W'((vocab_len[i - 1] % LETTERS_MAX) + 1);
                vocab_letters[i] = vocab_letters[i - 1];
            end
            else
            begin
                vocab_len[i] = LEN_W'($urandom_range(1, LETTERS_MAX));
                vocab_letters[i] = {$urandom, $urandom};
            end
            vocab_letters[i] = vocab_letters[i] & letter_mask(vocab_len[i]);
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(MODE_REMOVE, 64'h61, 4'd1);
        send_request(MODE_ADD, '1, 4'd0);
        send_request(MODE_REMOVE, 64'h61, 4'd9);
        send_request(MODE_ADD, 64'hFFFF_FFFF_FFFF_6261, 4'd2);
        send_request(MODE_ADD, 64'h1234_5678_9ABC_6261, 4'd2);
        send_request(MODE_ADD, 64'h6261, 4'd3);
        send_request(MODE_ADD, '1, 4'd8);
        send_request(MODE_ADD, 64'hABCD_EF00, 4'd1);
        send_request(MODE_REMOVE, 64'h6261, 4'd2);
        send_request(MODE_REMOVE, 64'h6261, 4'd2);
        send_request(MODE_REMOVE, 64'h6261, 4'd2);
        for (int i = 0; i < 13; i++)
            send_request(MODE_ADD, 64'h0101_0101_0101_0101 * (i + 2), LEN_W'((i % 8) + 1));
        send_request(MODE_ADD, 64'h77, 4'd1);
        send_request(MODE_ADD, '1, 4'd8);
        send_request(MODE_REMOVE, 64'h0, 4'd1);

        // drift the fill level up and down, varying the idle mix per segment
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            add_pct = $urandom_range(25, 85);
            gap_pct = (seg % 3 == 0) ? 0 : $urandom_range(5, 40);
            stall_pct = (seg % 4 == 1) ? 0 : $urandom_range(5, 40);
            if (seg == 4)
            begin
                gap_pct = 0;
                hold_off_request = 1'b1;
            end
            in_segment = 0;
            while (in_segment < SEGMENT_ITEMS)
            begin
                if (gap_pct != 0 && $urandom_range(99) < gap_pct)
                    pause_sender($urandom_range(1, 10));
                send_random_item(add_pct, took);
                in_segment += took;
            end
        end

        // no idling from here on; bump the word at slot 0 up and down
        stall_pct = 0;
        if (word_table.used == 0)
            send_request(MODE_ADD, vocab_letters[0], vocab_len[0]);
        top_letters = word_table.letters[0];
        top_len = word_table.lens[0];
        send_request(MODE_ADD, top_letters, top_len);
        send_request(MODE_ADD, top_letters, top_len);
        send_request(MODE_REMOVE, top_letters, top_len);
        send_request(MODE_ADD, top_letters, top_len);
        in_segment = 0;
        while (in_segment < TAIL_ITEMS)
        begin
            send_random_item(50, took);
            in_segment += took;
        end
        in_valid <= 1'b0;

        while (word_table.pending_lookups.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (word_table.mismatches == 0 && word_table.pending_lookups.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

// ===== sim.f =====
design/wft_pkg.sv
design/wft_ram.sv
design/wft_unit.sv
design/word_frequency_table.sv
sim/testbench.sv
